@@ hw/rtl/vt52f_pkg.sv @@
// vt52f_pkg: shared types, character codes and column helpers for the
// vt52 escape-to-text filter; no dependencies, compiled first
`default_nettype none

package vt52f_pkg;

  // character codes
  localparam logic [7:0] ChEsc   = 8'd27;
  localparam logic [7:0] ChBs    = 8'd8;
  localparam logic [7:0] ChTab   = 8'd9;
  localparam logic [7:0] ChLf    = 8'd10;
  localparam logic [7:0] ChCr    = 8'd13;
  localparam logic [7:0] ChSpace = 8'd32;
  localparam logic [7:0] ChUpE   = 8'd69;
  localparam logic [7:0] ChUpY   = 8'd89;
  localparam logic [7:0] ChLowB  = 8'd98;
  localparam logic [7:0] ChLowC  = 8'd99;

  localparam logic [7:0] LineWidthReset = 8'd80;
  localparam logic [7:0] PosOffset      = 8'd32;

  // sequence lengths after esc
  localparam logic [1:0] SeqNone  = 2'd0;
  localparam logic [1:0] SeqShort = 2'd1;
  localparam logic [1:0] SeqArg   = 2'd2;
  localparam logic [1:0] SeqPos   = 2'd3;

  // command queue between front and back
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // up to three output runs caused by one input byte
  typedef struct packed {
    logic       has_nl;
    logic       has_sp;
    logic [7:0] sp_count;
    logic       has_byte;
    logic [7:0] data;
  } run_cmd_t;

  typedef struct packed {
    logic     valid;
    run_cmd_t cmd;
  } q_push_t;

  typedef struct packed {
    logic     valid;
    run_cmd_t cmd;
  } q_head_t;

  function automatic logic [7:0] sat_inc(input logic [7:0] c);
    return (c == 8'hff) ? 8'hff : c + 8'd1;
  endfunction

  function automatic logic [7:0] sat_dec(input logic [7:0] c);
    return (c == 8'h00) ? 8'h00 : c - 8'd1;
  endfunction

  // round up to the next multiple of eight, saturating at 255
  function automatic logic [7:0] tab_up(input logic [7:0] c);
    logic [8:0] v;
    v = ({1'b0, c} + 9'd8) & 9'h1f8;
    return v[8] ? 8'hff : v[7:0];
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/vt52f_stream_if.sv @@
// vt52f stream channels: input byte channel and output run channel
// valid/ready handshake; no dependencies
`default_nettype none

interface vt52f_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface vt52f_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [7:0] repeat_count;
  logic       last_of_run;

  modport source (output valid, output out_byte, output repeat_count,
                  output last_of_run, input ready);
  modport sink   (input valid, input out_byte, input repeat_count,
                  input last_of_run, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/vt52f_front.sv @@
// vt52f_front: accepts input bytes, tracks escape sequences and columns,
// and turns each byte into at most one run command; uses vt52f_pkg, vt52f_in_if
`default_nettype none

module vt52f_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [7:0]         cfg_wdata_i,
  vt52f_in_if.sink                in_i,
  input  wire logic               q_full_i,
  output vt52f_pkg::q_push_t      push_o
);
  import vt52f_pkg::*;

  logic [7:0] line_width_q;
  logic [1:0] seq_index_q, seq_index_d;
  logic [1:0] seq_length_q, seq_length_d;
  logic       seq_pos_q, seq_pos_d;
  logic [7:0] host_col_q, host_col_d;
  logic [7:0] term_col_q, term_col_d;
  logic       nl_pend_q, nl_pend_d;

  logic       accept;
  logic [1:0] idx_n;
  logic       finish;
  logic [7:0] max_col;
  logic [7:0] pos_col;
  logic [7:0] tcol;
  logic [7:0] b;
  run_cmd_t   cmd;

  assign in_i.ready = !q_full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign b          = in_i.in_byte;

  always_comb begin
    seq_index_d  = seq_index_q;
    seq_length_d = seq_length_q;
    seq_pos_d    = seq_pos_q;
    host_col_d   = host_col_q;
    term_col_d   = term_col_q;
    nl_pend_d    = nl_pend_q;
    cmd          = '0;
    idx_n        = seq_index_q + 2'd1;
    finish       = 1'b0;
    max_col      = (line_width_q == 8'd0) ? 8'd0 : line_width_q - 8'd1;
    pos_col      = (b < PosOffset) ? 8'd0 : b - PosOffset;
    if (pos_col > max_col) begin
      pos_col = max_col;
    end
    tcol         = term_col_q;

    if (seq_length_q != SeqNone) begin
      seq_index_d = idx_n;
      if (idx_n == 2'd1) begin
        if (b == ChUpE) begin
          cmd.has_nl   = 1'b1;
          cmd.sp_count = 8'd1;
          host_col_d   = 8'd0;
          finish       = 1'b1;
        end else if (b == ChLowB || b == ChLowC) begin
          seq_length_d = SeqArg;
        end else if (b == ChUpY) begin
          seq_pos_d    = 1'b1;
          seq_length_d = SeqPos;
        end else begin
          finish = 1'b1;
        end
      end else if (idx_n >= seq_length_q) begin
        finish = 1'b1;
      end
      if (finish) begin
        // cursor address: forward emits spaces, backward waits
        if (seq_pos_q) begin
          term_col_d = pos_col;
          if (pos_col > host_col_q) begin
            cmd.has_sp   = 1'b1;
            cmd.sp_count = pos_col - host_col_q;
            host_col_d   = pos_col;
          end else if (pos_col < host_col_q) begin
            nl_pend_d = 1'b1;
          end
        end
        seq_length_d = SeqNone;
        seq_pos_d    = 1'b0;
      end
    end else if (b == ChEsc) begin
      seq_pos_d    = 1'b0;
      seq_length_d = SeqShort;
      seq_index_d  = 2'd0;
    end else if (nl_pend_q && b == ChSpace) begin
      term_col_d = sat_inc(term_col_q);
    end else if (nl_pend_q && b == ChBs) begin
      term_col_d = sat_dec(term_col_q);
    end else if (nl_pend_q && b == ChTab) begin
      term_col_d = tab_up(term_col_q);
    end else begin
      if (nl_pend_q) begin
        if (b == ChCr || b == ChLf) begin
          tcol = 8'd0;
        end
        term_col_d = tcol;
        cmd.has_nl = 1'b1;
        nl_pend_d  = 1'b0;
        if (tcol != 8'd0 && tcol < line_width_q) begin
          cmd.has_sp   = 1'b1;
          cmd.sp_count = tcol;
          host_col_d   = tcol;
        end else begin
          host_col_d = 8'd0;
        end
      end
      case (b)
        ChBs:       host_col_d = sat_dec(host_col_d);
        ChTab:      host_col_d = tab_up(host_col_d);
        ChCr, ChLf: host_col_d = 8'd0;
        default:    host_col_d = sat_inc(host_col_d);
      endcase
      cmd.has_byte = 1'b1;
      cmd.data     = b;
    end
  end

  assign push_o.valid = accept && (cmd.has_nl || cmd.has_sp || cmd.has_byte);
  assign push_o.cmd   = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q <= LineWidthReset;
      seq_index_q  <= 2'd0;
      seq_length_q <= SeqNone;
      seq_pos_q    <= 1'b0;
      host_col_q   <= 8'd0;
      term_col_q   <= 8'd0;
      nl_pend_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        line_width_q <= cfg_wdata_i;
      end
      if (accept) begin
        seq_index_q  <= seq_index_d;
        seq_length_q <= seq_length_d;
        seq_pos_q    <= seq_pos_d;
        host_col_q   <= host_col_d;
        term_col_q   <= term_col_d;
        nl_pend_q    <= nl_pend_d;
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/vt52f_cmd_queue.sv @@
// vt52f_cmd_queue: small fifo of run commands between front and back
// uses vt52f_pkg
`default_nettype none

module vt52f_cmd_queue (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire vt52f_pkg::q_push_t push_i,
  output logic                    full_o,
  output vt52f_pkg::q_head_t      head_o,
  input  wire logic               pop_i
);
  import vt52f_pkg::*;

  run_cmd_t               mem_q [QDepth];
  logic [QPtrW-1:0]       wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0]       count_q;
  logic                   do_pop;

  assign full_o      = (count_q == QCntW'(QDepth));
  assign head_o.valid = (count_q != '0);
  assign head_o.cmd   = mem_q[rd_ptr_q];
  assign do_pop       = pop_i && head_o.valid;

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      mem_q[wr_ptr_q] <= push_i.cmd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i.valid) begin
        wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
      case ({push_i.valid, do_pop})
        2'b10:   count_q <= count_q + QCntW'(1);
        2'b01:   count_q <= count_q - QCntW'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/vt52f_back.sv @@
// vt52f_back: plays out queued runs, one per cycle while out_o is not
// stalled, into a registered output stage; uses vt52f_pkg, vt52f_out_if
`default_nettype none

module vt52f_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire vt52f_pkg::q_head_t head_i,
  output logic                    pop_o,
  vt52f_out_if.source             out_o
);
  import vt52f_pkg::*;

  logic       out_valid_q;
  logic [7:0] out_byte_q, out_cnt_q;
  logic       out_last_q;
  logic       nl_done_q, sp_done_q;

  logic       adv;
  logic       p_nl, p_sp;
  logic [7:0] sel_byte, sel_cnt;
  logic       sel_last;

  assign adv  = head_i.valid && (!out_valid_q || out_o.ready);
  assign p_nl = head_i.cmd.has_nl && !nl_done_q;
  assign p_sp = head_i.cmd.has_sp && !sp_done_q;

  // pick the first run not yet sent
  always_comb begin
    if (p_nl) begin
      sel_byte = ChLf;
      sel_cnt  = 8'd1;
      sel_last = !p_sp && !head_i.cmd.has_byte;
    end else if (p_sp) begin
      sel_byte = ChSpace;
      sel_cnt  = head_i.cmd.sp_count;
      sel_last = !head_i.cmd.has_byte;
    end else begin
      sel_byte = head_i.cmd.data;
      sel_cnt  = 8'd1;
      sel_last = 1'b1;
    end
  end

  assign pop_o = adv && sel_last;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_byte_q <= sel_byte;
      out_cnt_q  <= sel_cnt;
      out_last_q <= sel_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      nl_done_q   <= 1'b0;
      sp_done_q   <= 1'b0;
    end else begin
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (adv) begin
        if (sel_last) begin
          nl_done_q <= 1'b0;
          sp_done_q <= 1'b0;
        end else if (p_nl) begin
          nl_done_q <= 1'b1;
        end else begin
          sp_done_q <= 1'b1;
        end
      end
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.out_byte     = out_byte_q;
  assign out_o.repeat_count = out_cnt_q;
  assign out_o.last_of_run  = out_last_q;

endmodule

`default_nettype wire

@@ hw/rtl/vt52_escape_to_text_filter.sv @@
// vt52_escape_to_text_filter: top level joining front, command queue and back
// uses vt52f_pkg, vt52f_stream_if, vt52f_front, vt52f_cmd_queue, vt52f_back
//
// Usage:
//   in_i carries one byte of a vt52 terminal stream per item (valid/ready).
//   out_o carries runs: out_byte repeated repeat_count times; last_of_run
//   marks the final run caused by one input byte. An input byte gives zero
//   to three runs: an optional newline, an optional space run, the byte.
//   cfg_we_i/cfg_wdata_i write line_width; write it only while idle.
// Path: an accepted byte's command is written into the command queue and
//   its first run is then registered into the output stage on out_o.
// Throughput: one input byte per cycle is accepted while the four-entry
//   command queue has room; the back end sends one run per cycle while
//   out_o is not stalled, so a byte takes output time for each of its runs.
// Reset: line_width returns to 80, all columns and sequence state clear,
//   the queue empties and out_o drops valid.
// Stall: a stalled receiver holds the output register; the queue fills and
//   in_i.ready drops once four commands are waiting.
`default_nettype none

module vt52_escape_to_text_filter (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [7:0] cfg_wdata_i,
  vt52f_in_if.sink        in_i,
  vt52f_out_if.source     out_o
);
  import vt52f_pkg::*;

  q_push_t push;
  q_head_t head;
  logic    q_full;
  logic    pop;

  vt52f_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_i),
    .q_full_i    (q_full),
    .push_o      (push)
  );

  vt52f_cmd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (q_full),
    .head_o (head),
    .pop_i  (pop)
  );

  vt52f_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .pop_o  (pop),
    .out_o  (out_o)
  );

endmodule

`default_nettype wire

@@ hw/rtl/vt52f_checker.sv @@
// vt52f_checker: port-level assertions for the vt52 escape-to-text filter
// bound to vt52_escape_to_text_filter; no package needed
`default_nettype none

module vt52f_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [7:0] out_byte_i,
  input wire logic [7:0] repeat_count_i,
  input wire logic       last_of_run_i
);

  // a stalled run stays offered
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output run dropped while stalled");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(out_byte_i) && $stable(repeat_count_i) && $stable(last_of_run_i))
    else $error("output run changed while stalled");

  // zero-length runs are never sent
  a_nonzero_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> repeat_count_i != 8'd0)
    else $error("run of zero length");

  // only space runs repeat
  a_single_non_space: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_byte_i != 8'd32 |-> repeat_count_i == 8'd1)
    else $error("repeated run of a non-space byte");

endmodule

bind vt52_escape_to_text_filter vt52f_checker u_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_byte_i     (out_o.out_byte),
  .repeat_count_i (out_o.repeat_count),
  .last_of_run_i  (out_o.last_of_run)
);

`default_nettype wire
